/* src/lph_pkg.sv */
package lph_pkg;

	localparam int SLOTS      = 1024;
	localparam int SLOT_BITS  = 10;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 16;
	localparam int COUNT_BITS = 11;
	localparam int LOG2_MIN   = 4;
	localparam int LOG2_MAX   = 10;
	localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
	localparam int SLOT_WORD_BITS = ENTRY_BITS + 1;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [SLOT_BITS-1:0]  home;
	} lph_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PROBE,
		B_CMP,
		B_SH_NEXT,
		B_SH_RD,
		B_SH_HASH,
		B_CLEAR
	} back_state_t;

endpackage

/* src/lph_ram.sv */
module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/lph_fnv.sv */
module lph_fnv
	import lph_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [31:0]         hash
);

	logic                running_q;
	logic                done_q;
	logic [2:0]          idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         h_q;
	logic [7:0]          b;
	logic [31:0]         prod;

	assign b    = key_q[7:0];
	assign prod = (h_q ^ {24'd0, b}) * FNV_PRIME;

	// one byte per cycle, stop at the first zero byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				running_q <= 1'b1;
				idx_q     <= '0;
			end else if (running_q) begin
				if (b == 8'd0 || idx_q == 3'd7) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			key_q <= key;
			h_q   <= FNV_BASIS;
		end else if (running_q && b != 8'd0) begin
			h_q   <= prod;
			key_q <= key_q >> 8;
		end
	end

	assign done = done_q;
	assign hash = h_q;

endmodule

/* src/lph_front.sv */
module lph_front
	import lph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            command,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  busy,
	output logic                  q_valid,
	output lph_item_t             q_item,
	input  logic                  q_pop
);

	front_state_t          st_q, st_d;
	lph_item_t             item_q;
	lph_item_t             fifo_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            fill_q;
	logic [KEY_BITS-1:0]   canon;
	logic                  hash_done;
	logic [31:0]           hash;
	logic                  accept, push;

	// keep bytes up to the first zero byte
	always_comb begin
		logic stop;
		stop  = 1'b0;
		canon = '0;
		for (int i = 0; i < 8; i++) begin
			if (key[8*i +: 8] == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				canon[8*i +: 8] = key[8*i +: 8];
			end
		end
	end

	assign accept = start && st_q == F_IDLE;
	assign push   = st_q == F_PUSH && fill_q != 2'd2;
	assign busy   = st_q != F_IDLE;

	lph_fnv u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.key    (canon),
		.done   (hash_done),
		.hash   (hash)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			F_IDLE: begin
				if (start) st_d = F_HASH;
			end
			F_HASH: begin
				if (hash_done) st_d = F_PUSH;
			end
			F_PUSH: begin
				if (fill_q != 2'd2) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= F_IDLE;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			st_q <= st_d;
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd   <= command;
			item_q.key   <= canon;
			item_q.value <= value;
		end
		if (hash_done && st_q == F_HASH) begin
			item_q.home <= hash[SLOT_BITS-1:0];
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= item_q;
		end
	end

	assign q_valid = fill_q != 2'd0;
	assign q_item  = fifo_q[rd_ptr_q];

endmodule

/* src/lph_back.sv */
module lph_back
	import lph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            size_log2,
	input  logic                  q_valid,
	input  lph_item_t             q_item,
	output logic                  q_pop,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] found_value,
	output logic [COUNT_BITS-1:0] live_count
);

	back_state_t           st_q, st_d;
	logic [SLOT_BITS-1:0]  clr_q;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SLOT_BITS-1:0]  pos_q, gap_q, j_q, jn;
	logic [COUNT_BITS-1:0] n_q, m_q;
	logic [ENTRY_BITS-1:0] ent_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [VALUE_BITS-1:0] fv_q;
	logic [COUNT_BITS-1:0] live_q;

	logic [3:0]                t_eff;
	logic [COUNT_BITS-1:0]     size, half;
	logic [SLOT_BITS-1:0]      mask, home, rd_addr, wr_addr;
	logic [SLOT_WORD_BITS-1:0] rd_data, wr_data;
	logic                      rd_used;
	logic                      wr_en, match, move;
	logic                      emit;
	logic [1:0]                emit_status;
	logic [VALUE_BITS-1:0]     emit_fv;
	logic                      hash_done;
	logic [31:0]               hash;

	always_comb begin
		t_eff = size_log2;
		if (size_log2 < 4'(LOG2_MIN)) t_eff = 4'(LOG2_MIN);
		if (size_log2 > 4'(LOG2_MAX)) t_eff = 4'(LOG2_MAX);
	end

	assign size    = COUNT_BITS'(1) << t_eff;
	assign half    = size >> 1;
	assign mask    = SLOT_BITS'(size - COUNT_BITS'(1));
	assign jn      = (j_q + SLOT_BITS'(1)) & mask;
	assign rd_used = rd_data[ENTRY_BITS];
	assign match   = rd_data[ENTRY_BITS-1:VALUE_BITS] == key_q;
	assign home    = hash[SLOT_BITS-1:0] & mask;
	assign move    = ((gap_q - home) & mask) <= ((j_q - home) & mask);
	assign rd_addr = (st_q == B_SH_NEXT) ? jn : pos_q;

	// slot word: used mark on top, then key, then value
	lph_ram #(.WIDTH(SLOT_WORD_BITS), .DEPTH(SLOTS)) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lph_fnv u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (st_q == B_SH_RD && rd_used),
		.key    (rd_data[ENTRY_BITS-1:VALUE_BITS]),
		.done   (hash_done),
		.hash   (hash)
	);

	always_comb begin
		st_d        = st_q;
		q_pop       = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = pos_q;
		wr_data     = {1'b1, key_q, val_q};
		emit        = 1'b0;
		emit_status = ST_ABSENT;
		emit_fv     = '0;
		cnt_d       = cnt_q;
		case (st_q)
			B_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == SLOT_BITS'(SLOTS - 1)) st_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.cmd == CMD_NONE) begin
						emit = 1'b1;
					end else begin
						st_d = B_PROBE;
					end
				end
			end
			B_PROBE: begin
				st_d = B_CMP;
			end
			B_CMP: begin
				if (!rd_used) begin
					emit = 1'b1;
					st_d = B_IDLE;
					if (cmd_q == CMD_INSERT) begin
						if (cnt_q <= half) begin
							wr_en       = 1'b1;
							cnt_d       = cnt_q + COUNT_BITS'(1);
							emit_status = ST_OK;
						end else begin
							emit_status = ST_FULL;
						end
					end
				end else if (match) begin
					case (cmd_q)
						CMD_LOOKUP: begin
							emit        = 1'b1;
							emit_status = ST_OK;
							emit_fv     = rd_data[VALUE_BITS-1:0];
							st_d        = B_IDLE;
						end
						CMD_INSERT: begin
							wr_en       = 1'b1;
							emit        = 1'b1;
							emit_status = ST_OK;
							st_d        = B_IDLE;
						end
						default: begin
							if (cnt_q != '0) cnt_d = cnt_q - COUNT_BITS'(1);
							st_d = B_SH_NEXT;
						end
					endcase
				end else if (n_q + COUNT_BITS'(1) == size) begin
					emit        = 1'b1;
					emit_status = (cmd_q == CMD_INSERT) ? ST_FULL : ST_ABSENT;
					st_d        = B_IDLE;
				end else begin
					st_d = B_PROBE;
				end
			end
			B_SH_NEXT: begin
				if ({1'b0, m_q} + 12'd1 >= {1'b0, size}) begin
					// walk limit reached: drop the used mark of the last gap
					wr_en       = 1'b1;
					wr_addr     = gap_q;
					wr_data     = '0;
					emit        = 1'b1;
					emit_status = ST_OK;
					st_d        = B_IDLE;
				end else begin
					st_d = B_SH_RD;
				end
			end
			B_SH_RD: begin
				if (!rd_used) begin
					wr_en       = 1'b1;
					wr_addr     = gap_q;
					wr_data     = '0;
					emit        = 1'b1;
					emit_status = ST_OK;
					st_d        = B_IDLE;
				end else begin
					st_d = B_SH_HASH;
				end
			end
			B_SH_HASH: begin
				if (hash_done) begin
					st_d = B_SH_NEXT;
					if (move) begin
						wr_en   = 1'b1;
						wr_addr = gap_q;
						wr_data = {1'b1, ent_q};
					end
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_CLEAR;
			clr_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			done_q <= emit;
			if (st_q == B_CLEAR) clr_q <= clr_q + SLOT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			fv_q     <= emit_fv;
			live_q   <= cnt_d;
		end
		case (st_q)
			B_IDLE: begin
				cmd_q <= q_item.cmd;
				key_q <= q_item.key;
				val_q <= q_item.value;
				pos_q <= q_item.home & mask;
				n_q   <= '0;
			end
			B_CMP: begin
				n_q   <= n_q + COUNT_BITS'(1);
				pos_q <= (pos_q + SLOT_BITS'(1)) & mask;
				gap_q <= pos_q;
				j_q   <= pos_q;
				m_q   <= '0;
			end
			B_SH_NEXT: begin
				j_q <= jn;
			end
			B_SH_RD: begin
				ent_q <= rd_data[ENTRY_BITS-1:0];
			end
			B_SH_HASH: begin
				if (hash_done) begin
					m_q <= m_q + COUNT_BITS'(1);
					if (move) gap_q <= j_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = fv_q;
	assign live_count  = live_q;

endmodule

/* src/linear_probe_hash_table_core.sv */
// Hash table of key/value pairs, open addressing with linear probing.
// Input word: start with command, key and value; taken when start is high and
// busy is low. busy stays high while the key is hashed and until the word is
// placed in a two-entry queue toward the table engine.
// Result word: done is high for one cycle with status, found_value and
// live_count. There is no stall on this side; the word must be taken then.
// Hashing reads one key byte per cycle and stops at the first zero byte or
// after the eighth byte; busy is high while the key is hashed, and the next
// word can be taken once busy drops, or later while the queue is full. Each
// probed slot takes an address step, then a registered read. A remove walks
// the cluster after the hole in a backward shift and rehashes each candidate.
// Sustained rate is set by the engine.
// table_size_log2 is written with table_size_log2_we; change it only idle.
// Reset sets the size to 1024 and the live count to zero; after reset the
// engine clears the used marks of all 1024 slots, and words taken in that
// time wait in the queue.
module linear_probe_hash_table_core
	import lph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  table_size_log2_we,
	input  logic [3:0]            table_size_log2,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] found_value,
	output logic [COUNT_BITS-1:0] live_count
);

	logic       size_we_unused;
	logic [3:0] size_log2_q;
	logic       q_valid, q_pop;
	lph_item_t  q_item;

	assign size_we_unused = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= 4'(LOG2_MAX);
		end else if (table_size_log2_we || size_we_unused) begin
			size_log2_q <= table_size_log2;
		end
	end

	lph_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.key     (key),
		.value   (value),
		.busy    (busy),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	lph_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.size_log2   (size_log2_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.live_count  (live_count)
	);

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_ABSENT || status == ST_FULL))
		else $error("bad status code");

	a_fv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> found_value == '0)
		else $error("found_value set on miss");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> live_count <= COUNT_BITS'(SLOTS))
		else $error("live count out of range");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after taking a word");
`endif

endmodule

/* tb/linear_probe_hash_table_core_tb.sv */
module linear_probe_hash_table_core_tb;
	import lph_pkg::*;

	typedef struct {
		logic [1:0]            status;
		logic [VALUE_BITS-1:0] found_value;
		logic [COUNT_BITS-1:0] live_count;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            command;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic                  table_size_log2_we;
	logic [3:0]            table_size_log2;
	logic                  done;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] found_value;
	logic [COUNT_BITS-1:0] live_count;

	// shadow copy of the table
	logic [KEY_BITS-1:0]   tbl_key [SLOTS];
	logic [VALUE_BITS-1:0] tbl_val [SLOTS];
	bit                    tbl_used [SLOTS];
	int unsigned           tbl_count;
	logic [3:0]            tbl_log2;

	answer_t               pending_answers[$];
	logic [KEY_BITS-1:0]   key_pool[$];
	int                    mismatches;
	int                    cycles;
	bit                    idle_on;

	linear_probe_hash_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.key(key), .value(value), .table_size_log2_we(table_size_log2_we),
		.table_size_log2(table_size_log2), .done(done), .status(status),
		.found_value(found_value), .live_count(live_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("linear_probe_hash_table_core_tb: errors");
			$finish;
		end
	end

	function automatic logic [KEY_BITS-1:0] key_trim(logic [KEY_BITS-1:0] k);
		logic [KEY_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 8'h00)
				break;
			r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	function automatic logic [31:0] fnv1a(logic [KEY_BITS-1:0] k);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 8'h00)
				break;
			h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic int unsigned slot_count();
		int unsigned t;
		t = tbl_log2;
		if (t < LOG2_MIN)
			t = LOG2_MIN;
		if (t > LOG2_MAX)
			t = LOG2_MAX;
		return 1 << t;
	endfunction

	function automatic bit probe_for(logic [KEY_BITS-1:0] k, output int unsigned at);
		int unsigned size, mask, h;
		size = slot_count();
		mask = size - 1;
		h = fnv1a(k) & mask;
		at = 0;
		for (int unsigned n = 0; n < size; n++) begin
			if (!tbl_used[h])
				return 0;
			if (tbl_key[h] == k) begin
				at = h;
				return 1;
			end
			h = (h + 1) & mask;
		end
		return 0;
	endfunction

	function automatic answer_t table_apply(logic [1:0] cmd, logic [KEY_BITS-1:0] raw,
			logic [VALUE_BITS-1:0] v);
		answer_t a;
		logic [KEY_BITS-1:0] k;
		int unsigned size, mask, h, s, gap, j, home;
		k = key_trim(raw);
		size = slot_count();
		mask = size - 1;
		a.status = ST_ABSENT;
		a.found_value = '0;
		case (cmd)
			CMD_LOOKUP: begin
				if (probe_for(k, s)) begin
					a.status = ST_OK;
					a.found_value = tbl_val[s];
				end
			end
			CMD_INSERT: begin
				h = fnv1a(k) & mask;
				a.status = ST_FULL;
				for (int unsigned n = 0; n < size; n++) begin
					if (!tbl_used[h]) begin
						if (tbl_count <= size / 2) begin
							tbl_key[h] = k;
							tbl_val[h] = v;
							tbl_used[h] = 1;
							tbl_count++;
							a.status = ST_OK;
						end
						break;
					end
					if (tbl_key[h] == k) begin
						tbl_val[h] = v;
						a.status = ST_OK;
						break;
					end
					h = (h + 1) & mask;
				end
			end
			CMD_REMOVE: begin
				if (probe_for(k, s)) begin
					gap = s;
					j = s;
					tbl_used[s] = 0;
					if (tbl_count > 0)
						tbl_count--;
					// backward shift: pull later cluster members into the hole
					for (int unsigned n = 0; n + 1 < size; n++) begin
						j = (j + 1) & mask;
						if (!tbl_used[j])
							break;
						home = fnv1a(tbl_key[j]) & mask;
						if (((gap - home) & mask) <= ((j - home) & mask)) begin
							tbl_key[gap] = tbl_key[j];
							tbl_val[gap] = tbl_val[j];
							tbl_used[gap] = 1;
							tbl_used[j] = 0;
							gap = j;
						end
					end
					a.status = ST_OK;
				end
			end
			default: ;
		endcase
		a.live_count = tbl_count[COUNT_BITS-1:0];
		return a;
	endfunction

	// random key: 0..8 nonzero bytes; if fewer than 8, a zero byte and junk after it
	function automatic logic [KEY_BITS-1:0] rand_key();
		logic [KEY_BITS-1:0] k;
		int len;
		len = $urandom_range(0, 8);
		k = {$urandom, $urandom};
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		if (len < 8)
			k[8*len +: 8] = 8'h00;
		return k;
	endfunction

	// same key, fresh junk past the terminator
	function automatic logic [KEY_BITS-1:0] rejunk(logic [KEY_BITS-1:0] k);
		logic [KEY_BITS-1:0] r;
		int len;
		r = key_trim(k);
		len = 0;
		while (len < 8 && r[8*len +: 8] != 8'h00)
			len++;
		for (int i = len + 1; i < 8; i++)
			r[8*i +: 8] = 8'($urandom);
		return r;
	endfunction

	task automatic send_word(logic [1:0] cmd, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		key <= k;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_answers.push_back(table_apply(cmd, k, v));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(logic [3:0] v);
		drain();
		table_size_log2_we <= 1'b1;
		table_size_log2 <= v;
		@(posedge clk);
		table_size_log2_we <= 1'b0;
		tbl_log2 = v;
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d value %h count %0d",
						status, found_value, live_count);
			end else begin
				e = pending_answers.pop_front();
				if (status !== e.status || found_value !== e.found_value
						|| live_count !== e.live_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							e.status, e.found_value, e.live_count,
							status, found_value, live_count);
				end
			end
		end
	end

	task automatic test_directed();
		send_word(CMD_LOOKUP, 64'd0, 16'hffff);
		send_word(CMD_INSERT, 64'd0, 16'h0000);
		send_word(CMD_LOOKUP, 64'hff00_1234_5678_9abc, 16'h0);
		send_word(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 16'hffff);
		send_word(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'h0);
		send_word(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 16'h5a5a);
		send_word(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'h0);
		send_word(CMD_NONE, 64'hffff_ffff_ffff_ffff, 16'hffff);
		send_word(CMD_REMOVE, 64'h0000_0000_0000_0041, 16'h0);
		send_word(CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 16'h0);
		send_word(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'h0);
		send_word(CMD_REMOVE, 64'hab00_0000_0000_0000, 16'h0);
		send_word(CMD_LOOKUP, 64'd0, 16'h0);
		// below the minimum: acts as 16 slots; fill past half, then update and remove
		write_size(4'd0);
		for (int i = 1; i <= 11; i++)
			send_word(CMD_INSERT, 64'(i), 16'(i * 3));
		send_word(CMD_INSERT, 64'h0000_0000_0000_0003, 16'hbeef);
		send_word(CMD_REMOVE, 64'h0000_0000_0000_0002, 16'h0);
		send_word(CMD_LOOKUP, 64'h0000_0000_0000_0003, 16'h0);
		for (int i = 1; i <= 11; i++)
			send_word(CMD_REMOVE, 64'(i), 16'h0);
	endtask

	task automatic run_phase(logic [3:0] lg, int items);
		int unsigned size;
		int r;
		logic [1:0] cmd;
		write_size(lg);
		size = slot_count();
		key_pool.delete();
		for (int i = 0; i < size * 3 / 4 + 2 && i < 200; i++)
			key_pool.push_back(key_trim(rand_key()));
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			cmd = r < 40 ? CMD_INSERT : r < 70 ? CMD_LOOKUP : r < 95 ? CMD_REMOVE : CMD_NONE;
			if ($urandom_range(0, 9) == 0)
				send_word(cmd, rand_key(), 16'($urandom));
			else
				send_word(cmd, rejunk(key_pool[$urandom_range(0, key_pool.size() - 1)]),
					16'($urandom));
			if (i == items / 2 && $urandom_range(0, 1) == 0)
				drain();
		end
		foreach (key_pool[i])
			send_word(CMD_REMOVE, key_pool[i], 16'($urandom));
	endtask

	task automatic test_random();
		run_phase(4'd5, 190);
		drain();
		run_phase(4'd4, 190);
		run_phase(4'd7, 190);
		run_phase(4'd3, 190);
		run_phase(4'd6, 190);
		idle_on = 0;
		run_phase(4'd15, 190);
	endtask

	// shrink a loaded table so the small window wraps with no empty slot
	task automatic test_shrink_wrap();
		logic [KEY_BITS-1:0] k;
		write_size(4'd10);
		for (int i = 0; i < 300; i++)
			send_word(CMD_INSERT, rand_key(), 16'($urandom));
		write_size(4'd4);
		for (int i = 0; i < 30; i++) begin
			k = rand_key();
			send_word(CMD_LOOKUP, k, 16'h0);
			send_word(CMD_INSERT, k, 16'($urandom));
			send_word(CMD_REMOVE, k, 16'h0);
		end
		write_size(4'd10);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_LOOKUP;
		key = '0;
		value = '0;
		table_size_log2_we = 1'b0;
		table_size_log2 = 4'd10;
		mismatches = 0;
		idle_on = 1;
		tbl_count = 0;
		tbl_log2 = 4'd10;
		foreach (tbl_used[i])
			tbl_used[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_shrink_wrap();
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("linear_probe_hash_table_core_tb: clean");
		else
			$display("linear_probe_hash_table_core_tb: errors");
		$finish;
	end

endmodule

/* linear_probe_hash_table_core.f */
src/lph_pkg.sv
src/lph_ram.sv
src/lph_fnv.sv
src/lph_front.sv
src/lph_back.sv
src/linear_probe_hash_table_core.sv
tb/linear_probe_hash_table_core_tb.sv
